[design/b64_pkg.sv]
// Shared types and constants for the base64 stream decoder.
package b64_pkg;

    localparam logic [7:0] PAD_CHAR     = 8'h3D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_VT      = 8'h0B;
    localparam logic [7:0] CHAR_FF      = 8'h0C;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic [5:0] OFS_LOWER    = 6'h1A;
    localparam logic [5:0] OFS_DIGIT    = 6'h34;
    localparam logic [5:0] SEXTET_PLUS  = 6'h3E;
    localparam logic [5:0] SEXTET_SLASH = 6'h3F;

    localparam logic [1:0] POS_THIRD = 2'd2;
    localparam logic [1:0] POS_LAST  = 2'd3;

    typedef enum logic [1:0] {
        CLS_DATA,
        CLS_SPACE,
        CLS_PAD,
        CLS_BAD
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [5:0]  sextet;
    } char_info_t;

    typedef struct packed {
        logic [15:0] total_bytes;
        logic        stream_done;
        logic        bad_input;
        logic [1:0]  byte_count;
        logic [7:0]  out_byte2;
        logic [7:0]  out_byte1;
        logic [7:0]  out_byte0;
    } result_t;

endpackage

[design/base64_stream_decoder.sv]
// Base64 stream decoder top level: input register, decode step, result register.
//
// Input channel s_*: one character per beat in s_tdata[7:0]; s_tlast marks the
// last character of a stream. Output channel m_*: one result per finished group,
// per first error of a stream and per end-of-stream character. m_tdata carries
// the three decoded bytes, the valid byte count and the running byte total;
// m_tuser is the sticky error flag and m_tlast marks the end-of-stream result.
// Characters that produce no result (whitespace, partial groups) are absorbed.
// Throughput is one character per cycle unless a low m_tready stalls the output; a
// character accepted is held in the input register and its result, if any, is then
// written to the output register. The single decode step (class lookup, sextet shift,
// byte-total add) lies between the two registers.
// When m_tready is low with a result waiting, the input register still takes
// one more beat and then holds it; s_tready falls until the result is taken.
// Reset clears the group state, the error flag, the byte total and both valid
// flags; the block is ready for a new stream straight after reset.
module base64_stream_decoder
    import b64_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_byte0, out_byte1, out_byte2, byte_count,
                                   // total_bytes, zero fill
    output logic        m_tuser,   // bad_input
    output logic        m_tlast    // stream_done
);

    localparam int CNT_W = (COUNT_BITS < 16) ? COUNT_BITS : 16;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg, in_char_next;
    logic       in_last_reg, in_last_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg, out_res_next;

    logic       advance;
    logic       emit;
    char_info_t info;
    result_t    res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    b64_sextet_map u_map
    (
        .char_code (in_char_reg),
        .info      (info)
    );

    b64_group_core #(
        .CNT_W (CNT_W)
    ) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .info   (info),
        .eos    (in_last_reg),
        .emit   (emit),
        .result (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_char_next = in_char_reg;
        in_last_next = in_last_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
            in_char_next = s_tdata;
            in_last_next = s_tlast;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next = out_res_reg;
        if (advance)
        begin
            out_valid_next = emit;
            out_res_next = res;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_char_reg <= in_char_next;
        in_last_reg <= in_last_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.total_bytes, out_res_reg.byte_count,
                       out_res_reg.out_byte2, out_res_reg.out_byte1, out_res_reg.out_byte0};
    assign m_tuser  = out_res_reg.bad_input;
    assign m_tlast  = out_res_reg.stream_done;

endmodule

[design/b64_sextet_map.sv]
// Character classifier: whitespace, pad, alphabet value or invalid.
module b64_sextet_map
    import b64_pkg::*;
(
    input  logic [7:0] char_code,
    output char_info_t info
);

    logic [7:0] diff;

    always_comb
    begin
        diff = 8'd0;
        info.cls = CLS_BAD;
        info.sextet = 6'd0;
        if (char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_Z)
        begin
            diff = char_code - CHAR_UPPER_A;
            info.cls = CLS_DATA;
            info.sextet = diff[5:0];
        end
        else if (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z)
        begin
            diff = char_code - CHAR_LOWER_A;
            info.cls = CLS_DATA;
            info.sextet = diff[5:0] + OFS_LOWER;
        end
        else if (char_code >= CHAR_DIGIT_0 && char_code <= CHAR_DIGIT_9)
        begin
            diff = char_code - CHAR_DIGIT_0;
            info.cls = CLS_DATA;
            info.sextet = diff[5:0] + OFS_DIGIT;
        end
        else if (char_code == CHAR_PLUS)
        begin
            info.cls = CLS_DATA;
            info.sextet = SEXTET_PLUS;
        end
        else if (char_code == CHAR_SLASH)
        begin
            info.cls = CLS_DATA;
            info.sextet = SEXTET_SLASH;
        end
        else if (char_code == PAD_CHAR)
        begin
            info.cls = CLS_PAD;
        end
        else if (char_code == CHAR_TAB || char_code == CHAR_LF || char_code == CHAR_VT ||
                 char_code == CHAR_FF || char_code == CHAR_CR || char_code == CHAR_SPACE)
        begin
            info.cls = CLS_SPACE;
        end
    end

endmodule

[design/b64_group_core.sv]
// Group assembly state, padding and error checks, saturating byte total.
module b64_group_core
    import b64_pkg::*;
#(
    parameter int CNT_W = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  char_info_t info,
    input  logic       eos,
    output logic       emit,
    output result_t    result
);

    logic [1:0]       pos_reg, pos_next;
    logic [17:0]      store_reg, store_next;
    logic             tpad_reg, tpad_next;
    logic             err_reg, err_next;
    logic [CNT_W-1:0] total_reg, total_next;

    logic [23:0]      group;
    logic [1:0]       nbytes;
    logic             raise;
    logic [CNT_W:0]   sum;
    logic [1:0]       pos_upd;
    logic [17:0]      store_upd;
    logic             tpad_upd;
    logic [CNT_W-1:0] total_upd;

    always_comb
    begin
        pos_upd = pos_reg;
        store_upd = store_reg;
        tpad_upd = tpad_reg;
        group = 24'd0;
        nbytes = 2'd0;
        raise = 1'b0;
        if (!err_reg)
        begin
            case (info.cls)
                CLS_SPACE:
                begin
                end
                CLS_PAD:
                begin
                    if (pos_reg < POS_THIRD)
                    begin
                        raise = 1'b1;
                    end
                    else if (pos_reg == POS_THIRD)
                    begin
                        store_upd = {store_reg[11:0], 6'd0};
                        tpad_upd = 1'b1;
                        pos_upd = POS_LAST;
                    end
                    else
                    begin
                        group = {store_reg, 6'd0};
                        nbytes = tpad_reg ? 2'd1 : 2'd2;
                        pos_upd = 2'd0;
                        store_upd = 18'd0;
                        tpad_upd = 1'b0;
                    end
                end
                CLS_DATA:
                begin
                    if (pos_reg == POS_LAST && tpad_reg)
                    begin
                        raise = 1'b1;
                    end
                    else if (pos_reg == POS_LAST)
                    begin
                        group = {store_reg, info.sextet};
                        nbytes = 2'd3;
                        pos_upd = 2'd0;
                        store_upd = 18'd0;
                        tpad_upd = 1'b0;
                    end
                    else
                    begin
                        store_upd = {store_reg[11:0], info.sextet};
                        pos_upd = pos_reg + 2'd1;
                    end
                end
                default:
                begin
                    raise = 1'b1;
                end
            endcase
            if (!raise && eos && pos_upd == POS_LAST && tpad_upd)
            begin
                raise = 1'b1;
            end
        end
    end

    always_comb
    begin
        sum = {1'b0, total_reg} + (CNT_W + 1)'(nbytes);
        total_upd = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
    end

    always_comb
    begin
        emit = (nbytes != 2'd0) || raise || eos;
        result.out_byte0 = group[23:16];
        result.out_byte1 = (nbytes >= 2'd2) ? group[15:8] : 8'd0;
        result.out_byte2 = (nbytes == 2'd3) ? group[7:0] : 8'd0;
        result.byte_count = nbytes;
        result.bad_input = err_reg | raise;
        result.stream_done = eos;
        result.total_bytes = 16'(total_upd);
    end

    always_comb
    begin
        pos_next = pos_reg;
        store_next = store_reg;
        tpad_next = tpad_reg;
        err_next = err_reg;
        total_next = total_reg;
        if (step)
        begin
            if (eos)
            begin
                pos_next = 2'd0;
                store_next = 18'd0;
                tpad_next = 1'b0;
                err_next = 1'b0;
                total_next = '0;
            end
            else
            begin
                pos_next = pos_upd;
                store_next = store_upd;
                tpad_next = tpad_upd;
                err_next = err_reg | raise;
                total_next = total_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
            store_reg <= 18'd0;
            tpad_reg <= 1'b0;
            err_reg <= 1'b0;
            total_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            store_reg <= store_next;
            tpad_reg <= tpad_next;
            err_reg <= err_next;
            total_reg <= total_next;
        end
    end

endmodule

[tb/base64_stream_decoder_test.sv]
// Self-checking testbench for the base64 stream decoder: directed table and random streams.
module base64_stream_decoder_test
    import b64_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [1:0]  count;
        logic        bad;
        logic        done;
        logic [15:0] total;
    } decoded_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic       has_res;
        decoded_t   want;
    } beat_t;

    localparam logic [7:0] CHAR_UPPER_Q = 8'h51;
    localparam logic [15:0] SUM_LIMIT = 16'hFFFF;
    localparam int HOLD_CYCLES = 80;
    localparam logic [7:0] SPACE_SET [6] =
        '{CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR, CHAR_SPACE};

    localparam int N_DIRECTED = 24;
    localparam beat_t DIRECTED [N_DIRECTED] = '{
        '{CHAR_SPACE,   1'b0, 1'b1, 1'b0, '0},
        '{CHAR_UPPER_A, 1'b0, 1'b0, 1'b0, '0},
        '{CHAR_UPPER_A, 1'b0, 1'b0, 1'b0, '0},
        '{CHAR_UPPER_A, 1'b0, 1'b0, 1'b0, '0},
        '{CHAR_UPPER_A, 1'b0, 1'b1, 1'b1,
          '{8'h00, 8'h00, 8'h00, 2'd3, 1'b0, 1'b0, 16'd3}},
        '{CHAR_TAB,     1'b0, 1'b0, 1'b0, '0},
        '{CHAR_SLASH,   1'b0, 1'b0, 1'b0, '0},
        '{CHAR_LF,      1'b0, 1'b0, 1'b0, '0},
        '{CHAR_SLASH,   1'b0, 1'b0, 1'b0, '0},
        '{CHAR_VT,      1'b0, 1'b0, 1'b0, '0},
        '{CHAR_SLASH,   1'b0, 1'b0, 1'b0, '0},
        '{CHAR_FF,      1'b0, 1'b0, 1'b0, '0},
        '{CHAR_SLASH,   1'b0, 1'b1, 1'b1,
          '{8'hFF, 8'hFF, 8'hFF, 2'd3, 1'b0, 1'b0, 16'd6}},
        '{CHAR_CR,      1'b0, 1'b0, 1'b0, '0},
        '{CHAR_UPPER_Q, 1'b0, 1'b0, 1'b0, '0},
        '{CHAR_UPPER_Q, 1'b0, 1'b0, 1'b0, '0},
        '{PAD_CHAR,     1'b0, 1'b0, 1'b0, '0},
        '{PAD_CHAR,     1'b1, 1'b1, 1'b1,
          '{8'h41, 8'h00, 8'h00, 2'd1, 1'b0, 1'b1, 16'd7}},
        '{PAD_CHAR,     1'b0, 1'b1, 1'b1,
          '{8'h00, 8'h00, 8'h00, 2'd0, 1'b1, 1'b0, 16'd0}},
        '{8'hFF,        1'b0, 1'b1, 1'b0, '0},
        '{8'h00,        1'b1, 1'b1, 1'b1,
          '{8'h00, 8'h00, 8'h00, 2'd0, 1'b1, 1'b1, 16'd0}},
        '{CHAR_UPPER_Q, 1'b0, 1'b0, 1'b0, '0},
        '{CHAR_UPPER_Q, 1'b0, 1'b0, 1'b0, '0},
        '{PAD_CHAR,     1'b1, 1'b1, 1'b1,
          '{8'h00, 8'h00, 8'h00, 2'd0, 1'b1, 1'b1, 16'd0}}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_code
    logic        s_tlast;   // end_of_stream
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // out_byte0, out_byte1, out_byte2, byte_count, total_bytes
    logic        m_tuser;   // bad_input
    logic        m_tlast;   // stream_done

    logic [1:0]  grp_pos;
    logic [17:0] sextets;
    logic        third_pad;
    logic        err_seen;
    logic [15:0] byte_sum;

    decoded_t pending_results [$];
    int error_count = 0;
    int result_index = 0;
    int beats_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_go = 1'b0;

    base64_stream_decoder #(
        .COUNT_BITS(16)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("base64_stream_decoder_test: FAIL");
        $finish;
    end

    function automatic char_class_t classify_char(input logic [7:0] ch,
                                                  output logic [5:0] value);
        value = '0;
        if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z)
        begin
            value = 6'(ch - CHAR_UPPER_A);
            return CLS_DATA;
        end
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
        begin
            value = 6'(ch - CHAR_LOWER_A) + OFS_LOWER;
            return CLS_DATA;
        end
        if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9)
        begin
            value = 6'(ch - CHAR_DIGIT_0) + OFS_DIGIT;
            return CLS_DATA;
        end
        if (ch == CHAR_PLUS)
        begin
            value = SEXTET_PLUS;
            return CLS_DATA;
        end
        if (ch == CHAR_SLASH)
        begin
            value = SEXTET_SLASH;
            return CLS_DATA;
        end
        if (ch == PAD_CHAR)
            return CLS_PAD;
        foreach (SPACE_SET[i])
            if (ch == SPACE_SET[i])
                return CLS_SPACE;
        return CLS_BAD;
    endfunction

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < OFS_LOWER)
            return CHAR_UPPER_A + 8'(v);
        if (v < OFS_DIGIT)
            return CHAR_LOWER_A + 8'(v - OFS_LOWER);
        if (v < SEXTET_PLUS)
            return CHAR_DIGIT_0 + 8'(v - OFS_DIGIT);
        if (v == SEXTET_PLUS)
            return CHAR_PLUS;
        return CHAR_SLASH;
    endfunction

    task automatic clear_decoder_state(input bit whole);
        grp_pos = '0;
        sextets = '0;
        third_pad = 1'b0;
        if (whole)
        begin
            err_seen = 1'b0;
            byte_sum = '0;
        end
    endtask

    task automatic decode_char(input logic [7:0] ch, input logic last,
                               output bit emitted, output decoded_t res);
        char_class_t cls;
        logic [5:0]  v;
        logic        raise;
        logic [1:0]  n;
        logic [23:0] grp;
        logic [16:0] sum;
        raise = 1'b0;
        n = '0;
        grp = '0;
        if (!err_seen)
        begin
            cls = classify_char(ch, v);
            if (cls == CLS_PAD)
            begin
                if (grp_pos < POS_THIRD)
                    raise = 1'b1;
                else if (grp_pos == POS_THIRD)
                begin
                    sextets = {sextets[11:0], 6'd0};
                    third_pad = 1'b1;
                    grp_pos = POS_LAST;
                end
                else
                begin
                    grp = {sextets, 6'd0};
                    n = third_pad ? 2'd1 : 2'd2;
                    clear_decoder_state(1'b0);
                end
            end
            else if (cls == CLS_BAD)
                raise = 1'b1;
            else if (cls == CLS_DATA)
            begin
                if (grp_pos == POS_LAST && third_pad)
                    raise = 1'b1;
                else if (grp_pos == POS_LAST)
                begin
                    grp = {sextets, v};
                    n = 2'd3;
                    clear_decoder_state(1'b0);
                end
                else
                begin
                    sextets = {sextets[11:0], v};
                    grp_pos = grp_pos + 2'd1;
                end
            end
            if (!raise && last && grp_pos == POS_LAST && third_pad)
                raise = 1'b1;
        end
        if (raise)
            err_seen = 1'b1;
        if (n != 0)
        begin
            sum = {1'b0, byte_sum} + 17'(n);
            byte_sum = (sum > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : sum[15:0];
        end
        emitted = (n != 0) || raise || last;
        res.b0 = grp[23:16];
        res.b1 = (n >= 2) ? grp[15:8] : 8'h00;
        res.b2 = (n == 3) ? grp[7:0] : 8'h00;
        res.count = n;
        res.bad = err_seen;
        res.done = last;
        res.total = byte_sum;
        if (last)
            clear_decoder_state(1'b1);
    endtask

    task automatic send_beat(input beat_t b);
        bit       emitted;
        decoded_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b.ch;
        s_tlast <= b.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_char(b.ch, b.last, emitted, res);
        if (b.typed)
        begin
            if (b.has_res)
                pending_results.push_back(b.want);
        end
        else if (emitted)
            pending_results.push_back(res);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_char(input logic [7:0] ch, input logic last);
        beat_t b;
        b = '0;
        b.ch = ch;
        b.last = last;
        send_beat(b);
    endtask

    task automatic send_random_stream();
        logic [7:0]  text [$];
        logic [23:0] grp;
        int          kind;
        int          nbytes;
        int          rem;
        int          pos;
        bit          drop_pad;
        kind = $urandom_range(0, 99);
        if (kind < 85)
        begin
            nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(0, 9);
            drop_pad = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < nbytes; i += 3)
            begin
                grp = 24'($urandom);
                rem = nbytes - i;
                text.push_back(sextet_char(grp[23:18]));
                text.push_back(sextet_char(grp[17:12]));
                if (rem >= 2)
                    text.push_back(sextet_char(grp[11:6]));
                else if (!drop_pad)
                    text.push_back(PAD_CHAR);
                if (rem >= 3)
                    text.push_back(sextet_char(grp[5:0]));
                else if (!drop_pad)
                    text.push_back(PAD_CHAR);
            end
            if (kind >= 70 && text.size() > 0)
            begin
                pos = $urandom_range(0, text.size() - 1);
                text[pos] = $urandom_range(0, 1) ? PAD_CHAR : 8'($urandom_range(0, 255));
                if ($urandom_range(0, 2) == 0)
                    void'(text.pop_back());
            end
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                text.push_back(8'($urandom_range(0, 255)));
        end
        if (text.size() == 0)
            text.push_back(SPACE_SET[$urandom_range(0, 5)]);
        foreach (text[i])
        begin
            if ($urandom_range(0, 9) == 0)
                send_char(SPACE_SET[$urandom_range(0, 5)], 1'b0);
            send_char(text[i], i == text.size() - 1);
        end
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct, input int beats);
        int target;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        target = beats_sent + beats;
        while (beats_sent < target)
            send_random_stream();
    endtask

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", result_index, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        decoded_t got;
        decoded_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.b0 = m_tdata[7:0];
                got.b1 = m_tdata[15:8];
                got.b2 = m_tdata[23:16];
                got.count = m_tdata[25:24];
                got.total = m_tdata[41:26];
                got.bad = m_tuser;
                got.done = m_tlast;
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing expected");
                else
                begin
                    want = pending_results.pop_front();
                    check_field("out_byte0", 16'(got.b0), 16'(want.b0));
                    check_field("out_byte1", 16'(got.b1), 16'(want.b1));
                    check_field("out_byte2", 16'(got.b2), 16'(want.b2));
                    check_field("byte_count", 16'(got.count), 16'(want.count));
                    check_field("bad_input", 16'(got.bad), 16'(want.bad));
                    check_field("stream_done", 16'(got.done), 16'(want.done));
                    check_field("total_bytes", got.total, want.total);
                end
                result_index++;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        clear_decoder_state(1'b1);
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 15;
        recv_idle_pct = 45;
        foreach (DIRECTED[i])
            send_beat(DIRECTED[i]);

        hold_go = 1'b1;
        run_phase(15, 45, 400);
        run_phase(45, 15, 400);
        run_phase(0, 0, 320);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (error_count == 0)
            $display("base64_stream_decoder_test: PASS");
        else
            $display("base64_stream_decoder_test: FAIL");
        $finish;
    end

endmodule
